// ----- src/pca_pkg.sv -----
package pca_pkg;

  localparam int VAL_W = 48;
  localparam int DIV_W = 58;
  localparam int ACC_W = 80;
  localparam logic [5:0] DIV_STEPS = 6'd58;
  localparam logic [23:0] MS_TICKS = 24'd16777;
  localparam logic signed [VAL_W-1:0] VAL_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [VAL_W-1:0] VAL_MIN = 48'sh8000_0000_0000;

  localparam logic [2:0] CFG_GAIN_P   = 3'd0;
  localparam logic [2:0] CFG_GAIN_I   = 3'd1;
  localparam logic [2:0] CFG_GAIN_D   = 3'd2;
  localparam logic [2:0] CFG_OUT_LOW  = 3'd3;
  localparam logic [2:0] CFG_OUT_HIGH = 3'd4;

  typedef enum logic [3:0] {
    S_IDLE, S_PMUL, S_LODIV, S_HIDIV, S_INCMUL, S_CLAMP, S_DDIV, S_DMUL,
    S_IMUL, S_SUM, S_CHECK, S_FINISH
  } state_t;

  typedef enum logic [1:0] {MS_P, MS_INC, MS_D, MS_I} mul_sel_t;
  typedef enum logic [1:0] {DS_LO, DS_HI, DS_D} div_sel_t;

  typedef struct packed {
    logic     load;
    logic     clear;
    logic     mul_go;
    mul_sel_t mul_sel;
    logic     div_go;
    div_sel_t div_sel;
    logic     clamp;
    logic     sum;
    logic     hold;
    logic     commit;
  } cmd_t;

  typedef struct packed {
    logic mul_done;
    logic div_done;
    logic gi_pos;
    logic first;
    logic hold_cond;
  } status_t;

  function automatic logic signed [VAL_W-1:0] sat48(input logic signed [VAL_W+1:0] v);
    if (v > 50'(VAL_MAX)) return VAL_MAX;
    if (v < 50'(VAL_MIN)) return VAL_MIN;
    return v[VAL_W-1:0];
  endfunction

  // apply sign to a magnitude, saturating to the 48-bit range
  function automatic logic signed [VAL_W-1:0] fix48(input logic neg, input logic [63:0] mag);
    if (neg) begin
      if (mag >= 64'h8000_0000_0000) return VAL_MIN;
      return -$signed(mag[VAL_W-1:0]);
    end
    if (mag > 64'h7FFF_FFFF_FFFF) return VAL_MAX;
    return $signed(mag[VAL_W-1:0]);
  endfunction

endpackage

// ----- src/pca_ctrl.sv -----
module pca_ctrl import pca_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  logic    req_type,
  output logic    in_ready,
  input  logic    out_ready,
  output logic    out_valid,
  input  status_t sts,
  output cmd_t    cmd
);

  state_t state, state_next;
  logic   held, held_next;
  logic   out_valid_next;
  logic   accept, fire;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign fire     = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      held      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      held      <= held_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    held_next  = held;
    case (state)
      S_IDLE: begin
        held_next = 1'b0;
        if (accept && !req_type) state_next = S_PMUL;
      end
      S_PMUL:   if (sts.mul_done) state_next = sts.gi_pos ? S_LODIV : S_CLAMP;
      S_LODIV:  if (sts.div_done) state_next = S_HIDIV;
      S_HIDIV:  if (sts.div_done) state_next = S_INCMUL;
      S_INCMUL: if (sts.mul_done) state_next = S_CLAMP;
      S_CLAMP:  state_next = sts.first ? S_IMUL : S_DDIV;
      S_DDIV:   if (sts.div_done) state_next = S_DMUL;
      S_DMUL:   if (sts.mul_done) state_next = S_IMUL;
      S_IMUL:   if (sts.mul_done) state_next = S_SUM;
      S_SUM:    state_next = S_CHECK;
      S_CHECK: begin
        // hold the integral once and redo the integral term
        if (sts.hold_cond && !held) begin
          held_next  = 1'b1;
          state_next = S_IMUL;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: if (fire) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd         = '0;
    cmd.mul_sel = MS_P;
    cmd.div_sel = DS_LO;
    cmd.load    = accept && !req_type;
    cmd.clear   = accept && req_type;
    case (state)
      S_PMUL:   begin cmd.mul_go = 1'b1; cmd.mul_sel = MS_P;   end
      S_LODIV:  begin cmd.div_go = 1'b1; cmd.div_sel = DS_LO;  end
      S_HIDIV:  begin cmd.div_go = 1'b1; cmd.div_sel = DS_HI;  end
      S_INCMUL: begin cmd.mul_go = 1'b1; cmd.mul_sel = MS_INC; end
      S_CLAMP:  cmd.clamp = 1'b1;
      S_DDIV:   begin cmd.div_go = 1'b1; cmd.div_sel = DS_D;   end
      S_DMUL:   begin cmd.mul_go = 1'b1; cmd.mul_sel = MS_D;   end
      S_IMUL:   begin cmd.mul_go = 1'b1; cmd.mul_sel = MS_I;   end
      S_SUM:    cmd.sum = 1'b1;
      S_CHECK:  cmd.hold = sts.hold_cond && !held;
      S_FINISH: cmd.commit = fire;
      default:  cmd.load = cmd.load;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (state == S_FINISH && fire) out_valid_next = 1'b1;
    else if (out_ready)            out_valid_next = 1'b0;
  end

endmodule

// ----- src/pca_datapath.sv -----
module pca_datapath import pca_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_en,
  input  logic [2:0]         wr_index,
  input  logic [31:0]        wr_data,
  input  logic signed [31:0] target,
  input  logic signed [31:0] measured,
  input  logic [23:0]        step_time,
  input  cmd_t               cmd,
  output status_t            sts,
  output logic signed [31:0] drive,
  output logic               limited
);

  logic signed [31:0] gain_p, gain_i, gain_d, out_low, out_high;
  logic signed [47:0] integral_sum;
  logic signed [32:0] last_error;
  logic               first_step;

  logic signed [32:0] err;
  logic [23:0]        dt;
  logic signed [47:0] pterm, dterm, iterm, inc, lo, hi, cand, deriv, raw;

  logic signed [33:0] diff;
  logic [32:0]        err_mag;
  logic [33:0]        diff_mag;
  logic signed [47:0] low48, high48, bnd_lo, bnd_hi, isum;

  // shared multiplier: 32 x 48 in three 16-bit slices, high slice first
  logic              mbusy;
  logic [1:0]        mcnt;
  logic [31:0]       ma, ma_in;
  logic [47:0]       mb, mb_in;
  logic              mneg, mneg_in;
  logic [ACC_W-1:0]  macc;
  logic [15:0]       mslice;
  logic [63:0]       mmag;
  logic signed [47:0] mres;

  // shared divider: restoring, one quotient bit per cycle
  logic              dbusy;
  logic [5:0]        dcnt;
  logic [DIV_W-1:0]  dq, dq_in;
  logic [31:0]       dr, dd, dd_in;
  logic              dneg, dneg_in;
  logic [32:0]       dshift;
  logic              dbit;
  logic signed [47:0] dres;

  assign low48  = 48'(out_low);
  assign high48 = 48'(out_high);
  assign diff   = 34'(err) - 34'(last_error);
  assign err_mag  = err[32] ? 33'(-err) : 33'(err);
  assign diff_mag = diff[33] ? 34'(-diff) : 34'(diff);

  assign sts.gi_pos   = (gain_i > 32'sd0);
  assign sts.first    = first_step;
  assign sts.mul_done = mbusy && (mcnt == 2'd3);
  assign sts.div_done = dbusy && (dcnt == DIV_STEPS);
  assign sts.hold_cond = sts.gi_pos &&
    ((raw > high48 && err > 33'sd0) || (raw < low48 && err < 33'sd0));

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p   <= '0;
      gain_i   <= '0;
      gain_d   <= '0;
      out_low  <= 32'sh8000_0000;
      out_high <= 32'sh7FFF_FFFF;
    end else if (wr_en) begin
      case (wr_index)
        CFG_GAIN_P:   gain_p   <= wr_data;
        CFG_GAIN_I:   gain_i   <= wr_data;
        CFG_GAIN_D:   gain_d   <= wr_data;
        CFG_OUT_LOW:  out_low  <= wr_data;
        CFG_OUT_HIGH: out_high <= wr_data;
        default:      gain_p   <= gain_p;
      endcase
    end
  end

  always_comb begin
    ma_in   = '0;
    mb_in   = '0;
    mneg_in = 1'b0;
    case (cmd.mul_sel)
      MS_P: begin
        ma_in   = gain_p[31] ? 32'(-gain_p) : 32'(gain_p);
        mb_in   = 48'(err_mag);
        mneg_in = gain_p[31] ^ err[32];
      end
      MS_INC: begin
        ma_in   = 32'(dt);
        mb_in   = 48'(err_mag);
        mneg_in = err[32];
      end
      MS_D: begin
        ma_in   = gain_d[31] ? 32'(-gain_d) : 32'(gain_d);
        mb_in   = deriv[47] ? 48'(-deriv) : 48'(deriv);
        mneg_in = gain_d[31] ^ deriv[47];
      end
      MS_I: begin
        ma_in   = gain_i[31] ? 32'(-gain_i) : 32'(gain_i);
        mb_in   = cand[47] ? 48'(-cand) : 48'(cand);
        mneg_in = gain_i[31] ^ cand[47];
      end
      default: ma_in = '0;
    endcase
  end

  always_comb begin
    case (mcnt)
      2'd0:    mslice = mb[47:32];
      2'd1:    mslice = mb[31:16];
      default: mslice = mb[15:0];
    endcase
  end

  assign mmag = (cmd.mul_sel == MS_INC) ? 64'(macc[ACC_W-1:24]) : macc[ACC_W-1:16];
  assign mres = fix48(mneg, mmag);

  always_ff @(posedge clk) begin
    if (rst) begin
      mbusy <= 1'b0;
      mcnt  <= '0;
    end else if (!mbusy) begin
      if (cmd.mul_go) begin
        mbusy <= 1'b1;
        mcnt  <= '0;
      end
    end else if (mcnt == 2'd3) begin
      mbusy <= 1'b0;
    end else begin
      mcnt <= mcnt + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!mbusy && cmd.mul_go) begin
      ma   <= ma_in;
      mb   <= mb_in;
      mneg <= mneg_in;
      macc <= '0;
    end else if (mbusy && mcnt != 2'd3) begin
      macc <= {macc[ACC_W-17:0], 16'b0} + ACC_W'(ma * mslice);
    end
  end

  always_comb begin
    dq_in   = '0;
    dd_in   = '0;
    dneg_in = 1'b0;
    case (cmd.div_sel)
      DS_LO: begin
        dq_in   = {10'b0, (out_low[31] ? 32'(-out_low) : 32'(out_low)), 16'b0};
        dd_in   = gain_i;
        dneg_in = out_low[31];
      end
      DS_HI: begin
        dq_in   = {10'b0, (out_high[31] ? 32'(-out_high) : 32'(out_high)), 16'b0};
        dd_in   = gain_i;
        dneg_in = out_high[31];
      end
      DS_D: begin
        dq_in   = {diff_mag, 24'b0};
        dd_in   = 32'(dt);
        dneg_in = diff[33];
      end
      default: dd_in = 32'd1;
    endcase
  end

  assign dshift = {dr, dq[DIV_W-1]};
  assign dbit   = (dshift >= 33'(dd));
  assign dres   = fix48(dneg, 64'(dq));

  always_ff @(posedge clk) begin
    if (rst) begin
      dbusy <= 1'b0;
      dcnt  <= '0;
    end else if (!dbusy) begin
      if (cmd.div_go) begin
        dbusy <= 1'b1;
        dcnt  <= '0;
      end
    end else if (dcnt == DIV_STEPS) begin
      dbusy <= 1'b0;
    end else begin
      dcnt <= dcnt + 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!dbusy && cmd.div_go) begin
      dq   <= dq_in;
      dd   <= dd_in;
      dneg <= dneg_in;
      dr   <= '0;
    end else if (dbusy && dcnt != DIV_STEPS) begin
      dr <= dbit ? 32'(dshift - 33'(dd)) : dshift[31:0];
      dq <= {dq[DIV_W-2:0], dbit};
    end
  end

  assign isum   = sat48(50'(integral_sum) + 50'(inc));
  assign bnd_lo = (lo > hi) ? hi : lo;
  assign bnd_hi = (lo > hi) ? lo : hi;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      err <= 33'(target) - 33'(measured);
      dt  <= (step_time == 24'd0) ? MS_TICKS : step_time;
    end
    if (sts.mul_done) begin
      case (cmd.mul_sel)
        MS_P:    pterm <= mres;
        MS_INC:  inc   <= mres;
        MS_D:    dterm <= mres;
        MS_I:    iterm <= mres;
        default: pterm <= pterm;
      endcase
    end
    if (sts.div_done) begin
      case (cmd.div_sel)
        DS_LO:   lo    <= dres;
        DS_HI:   hi    <= dres;
        DS_D:    deriv <= dres;
        default: lo    <= lo;
      endcase
    end
    if (cmd.clamp) begin
      if (!sts.gi_pos)          cand <= '0;
      else if (isum < bnd_lo)   cand <= bnd_lo;
      else if (isum > bnd_hi)   cand <= bnd_hi;
      else                      cand <= isum;
      if (first_step) dterm <= '0;
    end
    if (cmd.hold) cand <= integral_sum;
    if (cmd.sum) raw <= sat48(50'(pterm) + 50'(iterm) + 50'(dterm));
    if (cmd.commit) begin
      limited <= (raw < low48) || (raw > high48);
      if (raw < low48)       drive <= out_low;
      else if (raw > high48) drive <= out_high;
      else                   drive <= raw[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      integral_sum <= '0;
      last_error   <= '0;
      first_step   <= 1'b1;
    end else if (cmd.commit) begin
      integral_sum <= cand;
      last_error   <= err;
      first_step   <= 1'b0;
    end
  end

endmodule

// ----- src/pid_conditional_antiwindup.sv -----
// PID controller step with conditional-integration anti-windup.
// Input channel (in_valid/in_ready) carries req_type, target, measured and
// step_time. A clear request (req_type 1) resets the integral, last error and
// first-step flag in the cycle it is accepted and produces no result. A compute
// request produces one result (drive, limited) on out_valid/out_ready.
// Configuration registers are written through wr_en/wr_index/wr_data
// (0 gain_p, 1 gain_i, 2 gain_d, 3 out_low, 4 out_high); the user writes them
// only while the block is idle, which the block does not itself enforce.
// One shared 32x16 multiplier and one shared restoring divider do the
// arithmetic. out_valid rises soonest after a compute is accepted with
// gain_i <= 0 on the first step, and latest with two bound divisions, one
// derivative division and an integral hold.
// One request is worked at a time; in_ready is high only when idle.
// The result sits in an output register, so the next request is taken while
// a stalled receiver holds the previous one; a finished compute then waits
// for that register to drain. Reset clears state and loads default limits.
module pid_conditional_antiwindup import pca_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               req_type,
  input  logic signed [31:0] target,
  input  logic signed [31:0] measured,
  input  logic [23:0]        step_time,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] drive,
  output logic               limited,
  input  logic               wr_en,
  input  logic [2:0]         wr_index,
  input  logic [31:0]        wr_data
);

  cmd_t    cmd;
  status_t sts;

  pca_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .req_type  (req_type),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .sts       (sts),
    .cmd       (cmd)
  );

  pca_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (wr_en),
    .wr_index  (wr_index),
    .wr_data   (wr_data),
    .target    (target),
    .measured  (measured),
    .step_time (step_time),
    .cmd       (cmd),
    .sts       (sts),
    .drive     (drive),
    .limited   (limited)
  );

endmodule

// ----- verif/tb_pid_conditional_antiwindup.sv -----
module tb_pid_conditional_antiwindup import pca_pkg::*; ();

  localparam int STALL_LIMIT = 4000;
  localparam longint P48 = 64'sh7FFF_FFFF_FFFF;
  localparam longint N48 = -P48 - 1;

  typedef struct {
    logic signed [31:0] drive;
    logic               limited;
  } drive_t;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_ready;
  logic req_type = 0;
  logic signed [31:0] target = 0;
  logic signed [31:0] measured = 0;
  logic [23:0] step_time = 0;
  logic out_valid;
  logic out_ready = 0;
  logic signed [31:0] drive;
  logic limited;
  logic wr_en = 0;
  logic [2:0] wr_index = 0;
  logic [31:0] wr_data = 0;

  pid_conditional_antiwindup uut (.*);

  initial forever #2 clk = ~clk;

  // controller copy: gains, limits and loop state
  longint kp, ki, kd, lim_lo, lim_hi;
  longint integ, prev_err;
  bit first_run;
  drive_t pending_drives[$];
  int errors = 0;
  int n_steps = 0, n_clears = 0, n_limited = 0, n_held = 0;
  bit calm = 0;
  int quiet_cycles = 0;

  function automatic longint clip48(longint v);
    if (v > P48) return P48;
    if (v < N48) return N48;
    return v;
  endfunction

  function automatic longint gain_mul(longint g, longint v);
    bit neg;
    longint unsigned ua, ub, hi, mag;
    neg = (g < 0) != (v < 0);
    ua = g < 0 ? -g : g;
    ub = v < 0 ? -v : v;
    hi = ua * (ub >> 24);
    if (hi > (64'd1 << 39)) mag = 64'd1 << 48;
    else mag = (hi << 8) + ((ua * (ub & 64'hFFFFFF)) >> 16);
    if (neg) return (mag >= (64'd1 << 47)) ? N48 : -longint'(mag);
    return (mag > P48) ? P48 : longint'(mag);
  endfunction

  function automatic void predict_drive(bit clr, logic signed [31:0] sp,
                                        logic signed [31:0] pv, logic [23:0] t);
    longint e, dt, cand, der, pt, dtm, raw, lo, hi, tmp;
    drive_t r;
    if (clr) begin
      integ = 0; prev_err = 0; first_run = 1; n_clears++;
      return;
    end
    e = longint'(sp) - longint'(pv);
    dt = (t == 0) ? longint'(MS_TICKS) : longint'(t);
    pt = gain_mul(kp, e);
    if (ki > 0) begin
      lo = (lim_lo * 65536) / ki;
      hi = (lim_hi * 65536) / ki;
      if (lo > hi) begin tmp = lo; lo = hi; hi = tmp; end
      cand = clip48(integ + (e * dt) / 16777216);
      if (cand < lo) cand = lo;
      else if (cand > hi) cand = hi;
    end else cand = 0;
    der = first_run ? 0 : clip48(((e - prev_err) * 16777216) / dt);
    dtm = gain_mul(kd, der);
    raw = clip48(pt + gain_mul(ki, cand) + dtm);
    if (ki > 0 && ((raw > lim_hi && e > 0) || (raw < lim_lo && e < 0))) begin
      cand = integ;
      raw = clip48(pt + gain_mul(ki, cand) + dtm);
      n_held++;
    end
    integ = cand; prev_err = e; first_run = 0;
    r.limited = 1;
    if (raw < lim_lo) r.drive = 32'(lim_lo);
    else if (raw > lim_hi) r.drive = 32'(lim_hi);
    else begin r.drive = 32'(raw); r.limited = 0; end
    if (r.limited) n_limited++;
    n_steps++;
    pending_drives.push_back(r);
  endfunction

  function automatic logic [31:0] rand32();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom_range(0, 1) ? $urandom_range(0, 32'h3_0000)
                                     : -$urandom_range(0, 32'h3_0000);
      default: return $urandom;
    endcase
  endfunction

  // drive the output-side stalls
  always @(posedge clk) begin
    if (rst || calm) out_ready <= 1;
    else if (out_ready && $urandom_range(0, 7) == 0) out_ready <= 0;
    else if (!out_ready && $urandom_range(0, 2) == 0) out_ready <= 1;
  end

  // check each result against the oldest prediction
  always @(posedge clk) begin
    drive_t e;
    if (!rst && out_valid && out_ready) begin
      if (pending_drives.size() == 0) begin
        $error("result with no request waiting: drive %h", drive);
        errors++;
      end else begin
        e = pending_drives.pop_front();
        if (drive !== e.drive) begin
          $error("drive: expected %h, actual %h", e.drive, drive);
          errors++;
        end
        if (limited !== e.limited) begin
          $error("limited: expected %b, actual %b", e.limited, limited);
          errors++;
        end
      end
    end
  end

  // watchdog on handshake activity
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // valid stays up after acceptance; the next request or a drain drops it
  task automatic send_request(bit clr, logic [31:0] sp, logic [31:0] pv, logic [23:0] t);
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 4);
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    req_type <= clr;
    target <= sp;
    measured <= pv;
    step_time <= t;
    do @(posedge clk); while (!in_ready);
    predict_drive(clr, sp, pv, t);
  endtask

  task automatic wait_drained();
    in_valid <= 0;
    while (pending_drives.size() != 0) @(posedge clk);
    // a clear may still be in flight after the last result
    repeat (250) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    wr_en <= 1;
    wr_index <= idx;
    wr_data <= val;
    @(posedge clk);
    case (idx)
      CFG_GAIN_P:   kp = longint'(signed'(val));
      CFG_GAIN_I:   ki = longint'(signed'(val));
      CFG_GAIN_D:   kd = longint'(signed'(val));
      CFG_OUT_LOW:  lim_lo = longint'(signed'(val));
      CFG_OUT_HIGH: lim_hi = longint'(signed'(val));
      default: ;
    endcase
  endtask

  task automatic set_gains(logic [31:0] p, logic [31:0] i, logic [31:0] d,
                           logic [31:0] lo, logic [31:0] hi);
    wait_drained();
    write_reg(CFG_GAIN_P, p);
    write_reg(CFG_GAIN_I, i);
    write_reg(CFG_GAIN_D, d);
    write_reg(CFG_OUT_LOW, lo);
    write_reg(CFG_OUT_HIGH, hi);
    wr_en <= 0;
  endtask

  task automatic test_defaults();
    send_request(0, 32'h0001_0000, 0, 0);
    send_request(0, 32'h7FFF_FFFF, 32'h8000_0000, 24'hFFFFFF);
    send_request(0, 32'h8000_0000, 32'h7FFF_FFFF, 24'd1);
  endtask

  task automatic test_directed();
    set_gains(32'h0002_0000, 32'h0001_0000, 32'h0000_8000, 32'hFFF6_0000, 32'h000A_0000);
    send_request(0, 32'h0005_0000, 0, 0);          // derivative against the last default-gain step
    send_request(0, 32'h0005_0000, 32'h0001_0000, 24'h10_0000);
    send_request(0, 32'h7FFF_FFFF, 32'h8000_0000, 24'hFFFFFF); // saturate high, hold
    send_request(0, 32'h8000_0000, 32'h7FFF_FFFF, 24'hFFFFFF); // saturate low
    send_request(0, 0, 0, 24'd1);                  // tiny dt derivative
    send_request(1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 24'hFFFFFF); // clear
    send_request(0, 32'h0003_0000, 0, 24'h80_0000);
    // non-positive integral gain, reversed limits
    set_gains(32'hFFFF_0000, 32'hFFFF_0000, 32'h7FFF_FFFF, 32'h0005_0000, 32'hFFFB_0000);
    send_request(0, 32'h0001_0000, 0, 24'h01_0000);
    send_request(0, 0, 32'h0001_0000, 24'h01_0000);
    send_request(0, 0, 0, 24'h01_0000);
    // positive gain_i with reversed bounds
    set_gains(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    send_request(0, 32'h0010_0000, 0, 24'hFFFFFF);
    send_request(0, 32'hFFF0_0000, 0, 24'hFFFFFF);
    send_request(1, 0, 0, 0);
    send_request(0, 32'h1234_5678, 32'h8765_4321, 24'h00_0002);
  endtask

  task automatic test_random_phases(int phases, int per_phase);
    logic [31:0] lo, hi;
    for (int ph = 0; ph < phases; ph++) begin
      lo = $urandom_range(0, 1) ? -$urandom_range(0, 32'h0100_0000) : rand32();
      hi = $urandom_range(0, 1) ? $urandom_range(0, 32'h0100_0000) : rand32();
      set_gains(rand32(), ($urandom_range(0, 3) != 0) ? $urandom_range(1, 32'h0004_0000)
                : rand32(), rand32(), lo, hi);
      if (ph == phases - 1) calm = 1;
      for (int n = 0; n < per_phase; n++) begin
        case ($urandom_range(0, 9))
          0: send_request(1, $urandom, $urandom, 24'($urandom));
          1, 2: send_request(0, rand32(), rand32(), 24'($urandom));
          default: send_request(0, $urandom_range(0, 32'h0008_0000) - 32'h0004_0000,
                                $urandom_range(0, 32'h0008_0000) - 32'h0004_0000,
                                $urandom_range(0, 3) == 0 ? 24'd0
                                : 24'($urandom_range(1, 24'h20_0000)));
        endcase
      end
    end
  endtask

  initial begin
    kp = 0; ki = 0; kd = 0; lim_lo = -64'sd2147483648; lim_hi = 64'sd2147483647;
    integ = 0; prev_err = 0; first_run = 1;
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_defaults();
    test_directed();
    test_random_phases(14, 123);
    wait_drained();
    $display("compute steps %0d, clears %0d, limited outputs %0d, integral holds %0d",
             n_steps, n_clears, n_limited, n_held);
    if (errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
